// ----- rtl/rsi_pkg.sv -----
package rsi_pkg;

   // limb size and fixed latency of the pipelined multiplier
   localparam int MUL_LIMB = 24;
   localparam int MUL_LAT  = 5;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ----- rtl/rsi_fifo.sv -----
module rsi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     pop,
   output logic [WIDTH-1:0]         rdata,
   output rsi_pkg::fifo_status_type status
);

   localparam int PW = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW:0]      wr_ff;
   logic [PW:0]      rd_ff;
   logic             do_push;
   logic             do_pop;

   assign status.empty = (wr_ff == rd_ff);
   assign status.full  = (wr_ff[PW-1:0] == rd_ff[PW-1:0]) && (wr_ff[PW] != rd_ff[PW]);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = entry_ff[rd_ff[PW-1:0]];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff[PW-1:0]] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + (PW+1)'(1);
         end
         if (do_pop) begin
            rd_ff <= rd_ff + (PW+1)'(1);
         end
      end
   end

endmodule

// ----- rtl/rsi_delay.sv -----
module rsi_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule

// ----- rtl/rsi_mul.sv -----
module rsi_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

   localparam int LB  = rsi_pkg::MUL_LIMB;
   localparam int NA  = (A_WIDTH + LB - 1) / LB;
   localparam int NB  = (B_WIDTH + LB - 1) / LB;
   localparam int MAW = NA * LB;
   localparam int MBW = NB * LB;
   localparam int PW  = MAW + MBW;
   localparam int RW  = A_WIDTH + B_WIDTH;
   localparam int SGW = rsi_pkg::MUL_LAT - 1;

   logic [A_WIDTH-1:0]     a_abs;
   logic [B_WIDTH-1:0]     b_abs;
   logic [MAW-1:0]         ma_ff;
   logic [MBW-1:0]         mb_ff;
   logic [2*LB-1:0]        pp_ff [NA][NB];
   logic [PW-1:0]          row_ff [NA];
   logic [PW-1:0]          row_in [NA];
   logic [PW-1:0]          mag_ff;
   logic [PW-1:0]          mag_in;
   logic [SGW-1:0]         sg_ff;
   logic signed [RW-1:0]   p_ff;

   assign a_abs = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
   assign b_abs = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);

   // limb products -> row sums -> total, one level per stage
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) << (j * LB));
         end
      end
      mag_in = '0;
      for (int i = 0; i < NA; i++) begin
         mag_in = mag_in + (row_ff[i] << (i * LB));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= MAW'(a_abs);
         mb_ff <= MBW'(b_abs);
         sg_ff <= {sg_ff[SGW-2:0], a[A_WIDTH-1] ^ b[B_WIDTH-1]};
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= ma_ff[i*LB +: LB] * mb_ff[j*LB +: LB];
            end
         end
         row_ff <= row_in;
         mag_ff <= mag_in;
         p_ff   <= sg_ff[SGW-1] ? RW'(-mag_ff) : RW'(mag_ff);
      end
   end

   assign p = p_ff;

endmodule

// ----- rtl/rsi_isqrt.sv -----
module rsi_isqrt #(
   parameter int X_WIDTH = 136
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [X_WIDTH-1:0]     x,
   output logic [X_WIDTH/2-1:0]   root
);

   localparam int N = X_WIDTH / 2;

   logic [X_WIDTH-1:0] num_ff [N];
   logic [X_WIDTH-1:0] res_ff [N];
   logic [X_WIDTH-1:0] num_in [N];
   logic [X_WIDTH-1:0] res_in [N];
   logic [X_WIDTH-1:0] pn [N];
   logic [X_WIDTH-1:0] pr [N];
   logic [X_WIDTH-1:0] tr [N];

   // one result bit per stage, test bit 4^(N-1-j) at stage j
   always_comb begin
      pn[0] = x;
      pr[0] = '0;
      for (int j = 1; j < N; j++) begin
         pn[j] = num_ff[j-1];
         pr[j] = res_ff[j-1];
      end
      for (int j = 0; j < N; j++) begin
         tr[j] = pr[j] + (X_WIDTH'(1) << (X_WIDTH - 2 - 2 * j));
         if (pn[j] >= tr[j]) begin
            num_in[j] = pn[j] - tr[j];
            res_in[j] = (pr[j] >> 1) + (X_WIDTH'(1) << (X_WIDTH - 2 - 2 * j));
         end else begin
            num_in[j] = pn[j];
            res_in[j] = pr[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         res_ff <= res_in;
      end
   end

   assign root = res_ff[N-1][N-1:0];

endmodule

// ----- rtl/rsi_div.sv -----
module rsi_div #(
   parameter int N_WIDTH   = 69,
   parameter int DEN_WIDTH = 66,
   parameter int Q_WIDTH   = 31,
   parameter int SHIFT     = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [N_WIDTH-1:0]   n,
   input  logic [DEN_WIDTH-1:0]        den,
   output logic [Q_WIDTH-1:0]          q
);

   localparam int NUMW = N_WIDTH - 1 + SHIFT;
   localparam int DSW  = DEN_WIDTH + Q_WIDTH;
   localparam int CW   = (NUMW > DSW) ? NUMW : DSW;
   localparam int NS   = Q_WIDTH + 1;

   logic [CW-1:0]        num_ff [NS];
   logic [CW-1:0]        num_in [NS];
   logic [DEN_WIDTH-1:0] den_ff [NS];
   logic [Q_WIDTH-1:0]   q_ff [NS];
   logic [Q_WIDTH-1:0]   q_in [NS];
   logic [CW-1:0]        tr [NS];
   logic [NS-1:0]        pos_ff;
   logic [NS-1:0]        sat_ff;
   logic                 pos0;
   logic                 sat0;

   // first stage: numerator scaled, non-positive and overflow flagged
   assign pos0 = !n[N_WIDTH-1] && (n != '0);
   assign sat0 = num_in[0] >= (CW'(den) << Q_WIDTH);

   always_comb begin
      num_in[0] = pos0 ? (CW'(n[N_WIDTH-2:0]) << SHIFT) : '0;
      q_in[0]   = '0;
      tr[0]     = '0;
      for (int s = 1; s < NS; s++) begin
         tr[s] = CW'(den_ff[s-1]) << (Q_WIDTH - s);
         if (num_ff[s-1] >= tr[s]) begin
            num_in[s] = num_ff[s-1] - tr[s];
            q_in[s]   = q_ff[s-1] | (Q_WIDTH'(1) << (Q_WIDTH - s));
         end else begin
            num_in[s] = num_ff[s-1];
            q_in[s]   = q_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff    <= num_in;
         q_ff      <= q_in;
         den_ff[0] <= den;
         pos_ff[0] <= pos0;
         sat_ff[0] <= sat0;
         for (int s = 1; s < NS; s++) begin
            den_ff[s] <= den_ff[s-1];
            pos_ff[s] <= pos_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
         end
      end
   end

   assign q = !pos_ff[NS-1] ? '0 : (sat_ff[NS-1] ? '1 : q_ff[NS-1]);

endmodule

// ----- rtl/rsi_front.sv -----
module rsi_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic signed [COORD_WIDTH-1:0]   origin_x,
   input  logic signed [COORD_WIDTH-1:0]   origin_y,
   input  logic signed [COORD_WIDTH-1:0]   origin_z,
   input  logic signed [COORD_WIDTH-1:0]   dir_x,
   input  logic signed [COORD_WIDTH-1:0]   dir_y,
   input  logic signed [COORD_WIDTH-1:0]   dir_z,
   input  logic signed [COORD_WIDTH-1:0]   center_x,
   input  logic signed [COORD_WIDTH-1:0]   center_y,
   input  logic signed [COORD_WIDTH-1:0]   center_z,
   input  logic [COORD_WIDTH-2:0]          radius,
   input  logic                            out_full,
   output logic                            out_valid,
   output logic signed [2*COORD_WIDTH+1:0] out_a,
   output logic signed [2*COORD_WIDTH+3:0] out_b,
   output logic signed [2*COORD_WIDTH+2:0] out_c,
   output logic                            out_zero
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = 2 * W + 2;
   localparam int BW = 2 * W + 4;
   localparam int CW = 2 * W + 3;
   localparam int FD = rsi_pkg::MUL_LAT + 3;

   logic [FD-1:0]         vld_ff;
   logic                  en;
   logic signed [W-1:0]   org_ff [3];
   logic signed [W-1:0]   dir_ff [3];
   logic signed [W-1:0]   cen_ff [3];
   logic signed [W-1:0]   dir1_ff [3];
   logic [W-2:0]          rad_ff;
   logic [W-2:0]          rad1_ff;
   logic signed [W:0]     v_ff [3];
   logic signed [2*W-1:0] dd [3];
   logic signed [2*W:0]   dv [3];
   logic signed [2*W+1:0] vv [3];
   logic signed [2*W-1:0] rr;
   logic signed [AW-1:0]  a_ff;
   logic signed [AW-1:0]  a_in;
   logic signed [BW-1:0]  b_ff;
   logic signed [BW-1:0]  b_in;
   logic signed [CW-1:0]  c_ff;
   logic signed [CW-1:0]  c_in;
   logic                  zero_ff;

   // whole pipe holds while its last beat waits on a full queue
   assign en   = !(vld_ff[FD-1] && out_full);
   assign full = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FD-2:0], push};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         org_ff[0] <= origin_x;
         org_ff[1] <= origin_y;
         org_ff[2] <= origin_z;
         dir_ff[0] <= dir_x;
         dir_ff[1] <= dir_y;
         dir_ff[2] <= dir_z;
         cen_ff[0] <= center_x;
         cen_ff[1] <= center_y;
         cen_ff[2] <= center_z;
         rad_ff    <= radius;
         for (int i = 0; i < 3; i++) begin
            v_ff[i]    <= (W+1)'(org_ff[i]) - (W+1)'(cen_ff[i]);
            dir1_ff[i] <= dir_ff[i];
         end
         rad1_ff <= rad_ff;
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
         zero_ff <= (a_in == '0);
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_dd (
         .clock(clock), .en(en), .a(dir1_ff[i]), .b(dir1_ff[i]), .p(dd[i])
      );
      rsi_mul #(.A_WIDTH(W), .B_WIDTH(W+1)) u_dv (
         .clock(clock), .en(en), .a(dir1_ff[i]), .b(v_ff[i]), .p(dv[i])
      );
      rsi_mul #(.A_WIDTH(W+1), .B_WIDTH(W+1)) u_vv (
         .clock(clock), .en(en), .a(v_ff[i]), .b(v_ff[i]), .p(vv[i])
      );
   end

   rsi_mul #(.A_WIDTH(W), .B_WIDTH(W)) u_rr (
      .clock(clock), .en(en),
      .a($signed({1'b0, rad1_ff})), .b($signed({1'b0, rad1_ff})), .p(rr)
   );

   always_comb begin
      a_in = AW'(dd[0]) + AW'(dd[1]) + AW'(dd[2]);
      b_in = (BW'(dv[0]) + BW'(dv[1]) + BW'(dv[2])) <<< 1;
      c_in = CW'(vv[0]) + CW'(vv[1]) + CW'(vv[2]) - CW'(rr);
   end

   assign out_valid = vld_ff[FD-1];
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_c     = c_ff;
   assign out_zero  = zero_ff;

endmodule

// ----- rtl/rsi_back.sv -----
module rsi_back #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_pop,
   input  logic signed [2*COORD_WIDTH+1:0] in_a,
   input  logic signed [2*COORD_WIDTH+3:0] in_b,
   input  logic signed [2*COORD_WIDTH+2:0] in_c,
   input  logic                            in_zero,
   input  logic                            out_full,
   output logic                            out_valid,
   output logic                            out_hit,
   output logic [COORD_WIDTH-2:0]          out_distance
);

   localparam int W   = COORD_WIDTH;
   localparam int AW  = 2 * W + 2;
   localparam int BW  = 2 * W + 4;
   localparam int CW  = 2 * W + 3;
   localparam int DW  = 4 * W + 9;
   localparam int XW  = DW - 1;
   localparam int SW  = XW / 2;
   localparam int NW  = 2 * W + 5;
   localparam int QW  = W - 1;
   localparam int ML  = rsi_pkg::MUL_LAT;
   localparam int BD  = ML + 5 + SW + QW;

   logic [BD-1:0]          vld_ff;
   logic                   en;
   logic signed [AW-1:0]   a0_ff;
   logic signed [BW-1:0]   b0_ff;
   logic signed [CW-1:0]   c0_ff;
   logic                   z0_ff;
   logic signed [2*BW-1:0] bb;
   logic signed [AW+CW-1:0] ac;
   logic [AW+BW:0]         abz_d;
   logic signed [AW-1:0]   a1;
   logic signed [BW-1:0]   b1;
   logic                   z1;
   logic signed [DW-1:0]   disc;
   logic [XW-1:0]          x_ff;
   logic                   miss2_ff;
   logic signed [AW-1:0]   a2_ff;
   logic signed [BW-1:0]   b2_ff;
   logic [SW-1:0]          s;
   logic [AW+BW:0]         mab_d;
   logic signed [AW-1:0]   a3;
   logic signed [BW-1:0]   b3;
   logic                   miss3;
   logic signed [NW-1:0]   nb;
   logic signed [NW-1:0]   n1_ff;
   logic signed [NW-1:0]   n2_ff;
   logic [AW-1:0]          den_ff;
   logic                   miss4_ff;
   logic                   miss5;
   logic [QW-1:0]          t1;
   logic [QW-1:0]          t2;
   logic                   hit_ff;
   logic [QW-1:0]          dist_ff;

   assign en     = !(vld_ff[BD-1] && out_full);
   assign in_pop = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[BD-2:0], in_valid};
      end
   end

   rsi_mul #(.A_WIDTH(BW), .B_WIDTH(BW)) u_bb (
      .clock(clock), .en(en), .a(b0_ff), .b(b0_ff), .p(bb)
   );
   rsi_mul #(.A_WIDTH(AW), .B_WIDTH(CW)) u_ac (
      .clock(clock), .en(en), .a(a0_ff), .b(c0_ff), .p(ac)
   );
   rsi_delay #(.WIDTH(AW+BW+1), .DEPTH(ML)) u_abz (
      .clock(clock), .en(en), .d({z0_ff, a0_ff, b0_ff}), .q(abz_d)
   );
   assign {z1, a1, b1} = abz_d;

   assign disc = DW'(bb) - (DW'(ac) <<< 2);

   rsi_isqrt #(.X_WIDTH(XW)) u_sqrt (
      .clock(clock), .en(en), .x(x_ff), .root(s)
   );
   rsi_delay #(.WIDTH(AW+BW+1), .DEPTH(SW)) u_mab (
      .clock(clock), .en(en), .d({miss2_ff, a2_ff, b2_ff}), .q(mab_d)
   );
   assign {miss3, a3, b3} = mab_d;

   assign nb = -NW'(b3);

   rsi_div #(.N_WIDTH(NW), .DEN_WIDTH(AW), .Q_WIDTH(QW), .SHIFT(FRAC_BITS)) u_div1 (
      .clock(clock), .en(en), .n(n1_ff), .den(den_ff), .q(t1)
   );
   rsi_div #(.N_WIDTH(NW), .DEN_WIDTH(AW), .Q_WIDTH(QW), .SHIFT(FRAC_BITS)) u_div2 (
      .clock(clock), .en(en), .n(n2_ff), .den(den_ff), .q(t2)
   );
   rsi_delay #(.WIDTH(1), .DEPTH(QW+1)) u_miss (
      .clock(clock), .en(en), .d(miss4_ff), .q(miss5)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         a0_ff    <= in_a;
         b0_ff    <= in_b;
         c0_ff    <= in_c;
         z0_ff    <= in_zero;
         // negative discriminant: root of zero keeps the sqrt pipe quiet
         x_ff     <= disc[DW-1] ? '0 : disc[XW-1:0];
         miss2_ff <= z1 || disc[DW-1];
         a2_ff    <= a1;
         b2_ff    <= b1;
         n1_ff    <= nb - $signed(NW'(s));
         n2_ff    <= nb + $signed(NW'(s));
         den_ff   <= {a3[AW-2:0], 1'b0};
         miss4_ff <= miss3;
         // t1 <= t2, so the near root wins when it is positive
         if (miss5) begin
            hit_ff  <= 1'b0;
            dist_ff <= '0;
         end else if (t1 != '0) begin
            hit_ff  <= 1'b1;
            dist_ff <= t1;
         end else begin
            hit_ff  <= (t2 != '0);
            dist_ff <= t2;
         end
      end
   end

   assign out_valid    = vld_ff[BD-1];
   assign out_hit      = hit_ff;
   assign out_distance = dist_ff;

endmodule

// ----- rtl/ray_sphere_intersect.sv -----
// Channel   Ports                         Beat taken when
// request   req_push / req_full + fields  req_push && !req_full
// response  rsp_empty / rsp_pop + fields  rsp_pop && !rsp_empty
//
// One beat accepted per cycle while req_full is low. A beat passes the front
// pipe, the middle queue, the back pipe (its depth set by the one-bit-per-stage
// square root and quotient) and then the response queue.
// Reset clears valid bits and queue pointers only; no sweep is needed.
// Each pipe stalls as a whole when its last beat meets a full queue.
module ray_sphere_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic [COORD_WIDTH-2:0]        req_radius,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic                          rsp_hit,
   output logic [COORD_WIDTH-2:0]        rsp_distance
);

   localparam int W       = COORD_WIDTH;
   localparam int AW      = 2 * W + 2;
   localparam int BW      = 2 * W + 4;
   localparam int CW      = 2 * W + 3;
   localparam int MIDW    = 1 + AW + BW + CW;
   localparam int QDEPTH  = 4;

   logic                     f_valid;
   logic signed [AW-1:0]     f_a;
   logic signed [BW-1:0]     f_b;
   logic signed [CW-1:0]     f_c;
   logic                     f_zero;
   logic [MIDW-1:0]          mid_rdata;
   rsi_pkg::fifo_status_type mid_st;
   logic                     b_pop;
   logic                     b_valid;
   logic                     b_hit;
   logic [W-2:0]             b_dist;
   logic [W-1:0]             out_rdata;
   rsi_pkg::fifo_status_type out_st;

   rsi_front #(.COORD_WIDTH(W)) u_front (
      .clock(clock), .reset(reset), .push(req_push), .full(req_full),
      .origin_x(req_origin_x), .origin_y(req_origin_y), .origin_z(req_origin_z),
      .dir_x(req_dir_x), .dir_y(req_dir_y), .dir_z(req_dir_z),
      .center_x(req_center_x), .center_y(req_center_y), .center_z(req_center_z),
      .radius(req_radius), .out_full(mid_st.full), .out_valid(f_valid),
      .out_a(f_a), .out_b(f_b), .out_c(f_c), .out_zero(f_zero)
   );

   rsi_fifo #(.WIDTH(MIDW), .DEPTH(QDEPTH)) u_mid (
      .clock(clock), .reset(reset), .push(f_valid),
      .wdata({f_zero, f_a, f_b, f_c}), .pop(b_pop), .rdata(mid_rdata), .status(mid_st)
   );

   rsi_back #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(!mid_st.empty), .in_pop(b_pop),
      .in_a(mid_rdata[BW+CW +: AW]), .in_b(mid_rdata[CW +: BW]),
      .in_c(mid_rdata[CW-1:0]), .in_zero(mid_rdata[MIDW-1]),
      .out_full(out_st.full), .out_valid(b_valid), .out_hit(b_hit), .out_distance(b_dist)
   );

   rsi_fifo #(.WIDTH(W), .DEPTH(QDEPTH)) u_out (
      .clock(clock), .reset(reset), .push(b_valid), .wdata({b_hit, b_dist}),
      .pop(rsp_pop), .rdata(out_rdata), .status(out_st)
   );

   assign rsp_empty    = out_st.empty;
   assign rsp_hit      = out_rdata[W-1];
   assign rsp_distance = out_rdata[W-2:0];

`ifndef SYNTHESIS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_hit |-> rsp_distance == '0)
      else $error("miss beat carries a nonzero distance");

   a_hit_positive: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_hit |-> rsp_distance != '0)
      else $error("hit beat carries a zero distance");

   a_reset_clean: assert property (@(posedge clock)
      !reset && $past(reset) |-> rsp_empty && !req_full)
      else $error("pipes not clear after reset");
`endif

endmodule

// ----- dv/ray_sphere_intersect_test.sv -----
module ray_sphere_intersect_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW    = 32;
   localparam int FB    = 16;
   localparam int ONE   = 1 << FB;
   localparam int WDOG  = 20000;
   localparam int NRAND = 800;
   localparam logic [CW-2:0] DIST_MAX = {(CW-1){1'b1}};

   typedef logic signed [159:0] wide_type;

   typedef struct {
      logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
      logic [CW-2:0]        radius;
   } ray_type;

   typedef struct {
      logic          hit;
      logic [CW-2:0] distance;
   } hit_type;

   typedef struct {
      ray_type ray;
      bit      fixed;
      hit_type want;
   } row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic signed [CW-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [CW-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic signed [CW-1:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [CW-2:0]        req_radius = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic                 rsp_hit;
   logic [CW-2:0]        rsp_distance;

   hit_type pending_hits[$];
   row_type directed_rows[$];
   int   mismatches = 0;
   int   phase = 0;          // 0: sender 29 / receiver 57, 1: swapped, 2: no idling
   bit   hold_request = 0;
   bit   sending_done = 0;
   int   quiet_cycles = 0;

   ray_sphere_intersect #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z),
      .req_dir_x(req_dir_x), .req_dir_y(req_dir_y), .req_dir_z(req_dir_z),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z),
      .req_radius(req_radius),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_hit(rsp_hit), .rsp_distance(rsp_distance)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // truncated Q16 quotient (n << FB) / den, saturated; zero when n <= 0
   function automatic logic [CW-2:0] root_q(input wide_type n, input wide_type den);
      wide_type num;
      if (n <= 0) return '0;
      num = n <<< FB;
      if (num >= (den <<< (CW-1))) return DIST_MAX;
      return (CW-1)'(num / den);
   endfunction

   function automatic hit_type predict_hit(input ray_type r);
      wide_type dx, dy, dz, vx, vy, vz, rr, qa, qb, qc, disc, s, probe;
      logic [CW-2:0] t1, t2;
      hit_type h;
      h.hit = 1'b0;
      h.distance = '0;
      dx = r.dx; dy = r.dy; dz = r.dz;
      vx = r.ox; vx = vx - r.cx;
      vy = r.oy; vy = vy - r.cy;
      vz = r.oz; vz = vz - r.cz;
      rr = {129'b0, r.radius};
      qa = dx*dx + dy*dy + dz*dz;
      qb = (dx*vx + dy*vy + dz*vz) <<< 1;
      qc = vx*vx + vy*vy + vz*vz - rr*rr;
      if (qa == 0) return h;
      disc = qb*qb - ((qa*qc) <<< 2);
      if (disc < 0) return h;
      s = 0;
      for (int k = 79; k >= 0; k--) begin
         probe = s | (wide_type'(1) <<< k);
         if (probe*probe <= disc) s = probe;
      end
      t1 = root_q(-qb - s, qa <<< 1);
      t2 = root_q(-qb + s, qa <<< 1);
      if (t1 != 0) begin
         h.hit = 1'b1; h.distance = t1;
      end else if (t2 != 0) begin
         h.hit = 1'b1; h.distance = t2;
      end
      return h;
   endfunction

   function automatic ray_type make_ray(input int ox, oy, oz, dx, dy, dz, cx, cy, cz,
                                        input int unsigned rad);
      ray_type r;
      r.ox = ox; r.oy = oy; r.oz = oz;
      r.dx = dx; r.dy = dy; r.dz = dz;
      r.cx = cx; r.cy = cy; r.cz = cz;
      r.radius = rad[CW-2:0];
      return r;
   endfunction

   task automatic add_row(input ray_type r, input bit fixed, input logic hit,
                          input logic [CW-2:0] want_dist);
      row_type w;
      w.ray = r; w.fixed = fixed; w.want.hit = hit; w.want.distance = want_dist;
      directed_rows.push_back(w);
   endtask

   function automatic int coord(input int span);
      return $urandom_range(2*span) - span;
   endfunction

   function automatic ray_type random_ray();
      ray_type r;
      int      sel;
      sel = $urandom_range(99);
      if (sel < 25) begin
         r.ox = $urandom; r.oy = $urandom; r.oz = $urandom;
         r.dx = $urandom; r.dy = $urandom; r.dz = $urandom;
         r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
         r.radius = (CW-1)'($urandom);
      end else begin
         // mostly rays aimed near a sphere, scale varies to cover big and tiny roots
         int sc;
         sc = (sel < 35) ? 1 : ONE;
         r.ox = coord(50) * sc + coord(ONE);
         r.oy = coord(50) * sc + coord(ONE);
         r.oz = coord(50) * sc + coord(ONE);
         r.dx = coord(4 * ONE); r.dy = coord(4 * ONE); r.dz = coord(4 * ONE);
         if (sel > 90) r.dy = coord(3);
         r.cx = r.ox + r.dx * coord(20) / 2 + coord(2 * ONE);
         r.cy = r.oy + r.dy * coord(20) / 2 + coord(2 * ONE);
         r.cz = r.oz + r.dz * coord(20) / 2 + coord(2 * ONE);
         r.radius = (CW-1)'($urandom_range(30 * ONE));
      end
      return r;
   endfunction

   task automatic send_ray(input ray_type r, input bit fixed, input hit_type want);
      if (phase < 2 && $urandom_range(99) < (phase == 0 ? 29 : 57)) begin
         req_push = 1'b0;
         do @(negedge clock); while ($urandom_range(99) < (phase == 0 ? 29 : 57));
      end
      req_push = 1'b1;
      req_origin_x = r.ox; req_origin_y = r.oy; req_origin_z = r.oz;
      req_dir_x = r.dx; req_dir_y = r.dy; req_dir_z = r.dz;
      req_center_x = r.cx; req_center_y = r.cy; req_center_z = r.cz;
      req_radius = r.radius;
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      pending_hits.push_back(fixed ? want : predict_hit(r));
      @(negedge clock);
   endtask

   // receiver
   initial begin
      int pause;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_pop = 1'b0;
            for (pause = 0; pause < 400; pause++) @(negedge clock);
            hold_request = 0;
         end
         rsp_pop = (phase == 2) ? 1'b1 : ($urandom_range(99) >= (phase == 0 ? 57 : 29));
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (pending_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected beat: hit=%0d distance=%0d", rsp_hit, rsp_distance);
            end else begin
               hit_type w;
               w = pending_hits.pop_front();
               if (rsp_hit !== w.hit || rsp_distance !== w.distance) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected hit=%0d distance=%0d, got hit=%0d distance=%0d",
                              w.hit, w.distance, rsp_hit, rsp_distance);
               end
            end
         end
         @(negedge clock);
      end
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG) begin
         $display("ray_sphere_intersect test failed");
         $finish;
      end
   end

   initial begin
      hit_type miss;
      miss.hit = 1'b0; miss.distance = '0;
      add_row(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 5 * ONE, ONE), 1, 1'b0, '0);
      add_row(make_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE), 1, 1'b1, ONE);
      add_row(make_ray(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, ONE), 1, 1'b0, '0);
      add_row(make_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 50 * ONE, 0, ONE), 1, 1'b0, '0);
      add_row(make_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE), 1, 1'b1, 4 * ONE);
      add_row(make_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, ONE, 0, ONE), 0, 0, 0);
      add_row(make_ray(0, 0, 0, 1, 0, 0, 30000 * ONE, 0, 0, ONE), 0, 0, 0);
      add_row(make_ray(0, 0, 0, 0, 0, -ONE, 0, 0, -3 * ONE, 2 * ONE), 0, 0, 0);
      add_row(make_ray(ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE), 0, 0, 0);
      add_row(make_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0), 0, 0, 0);
      add_row(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 31'h7fffffff), 0, 0, 0);
      add_row(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h7fffffff, 0), 0, 0, 0);
      add_row(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 31'h7fffffff), 0, 0, 0);
      add_row(make_ray(32'h80000000, 0, 0, 32'h80000000, 0, 0, 32'h7fffffff, 0, 0,
                       31'h7fffffff), 0, 0, 0);
      add_row(make_ray(0, 0, 0, 1, 1, 1, 100 * ONE, 100 * ONE, 100 * ONE, 31'h7fffffff),
              0, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_ray(directed_rows[i].ray, directed_rows[i].fixed, directed_rows[i].want);
      for (int n = 0; n < NRAND; n++) begin
         phase = n * 3 / NRAND;
         if (n == NRAND / 2) hold_request = 1;
         send_ray(random_ray(), 0, miss);
      end
      req_push = 1'b0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0 && pending_hits.size() == 0)
         $display("ray_sphere_intersect test passed");
      else
         $display("ray_sphere_intersect test failed");
      $finish;
   end
endmodule
